// ----- rtl/x86mov_pkg.sv -----
`default_nettype none

package x86mov_pkg;

    // Decoder phase: which byte of the instruction comes next
    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_MODRM   = 3'd1,
        PH_DISP_LO = 3'd2,
        PH_DISP_HI = 3'd3,
        PH_IMM_LO  = 3'd4,
        PH_IMM_HI  = 3'd5
    } phase_t;

    // Instruction form reported on the result stream
    typedef enum logic [1:0] {
        K_REGMEM  = 2'd0,
        K_IMM_RM  = 2'd1,
        K_IMM_REG = 2'd2,
        K_UNKNOWN = 2'd3
    } kind_t;

    // Opcode match patterns (byte & mask == pattern)
    localparam logic [7:0] OPC_REGMEM_MASK  = 8'hFC;
    localparam logic [7:0] OPC_REGMEM       = 8'h88;
    localparam logic [7:0] OPC_IMM_RM_MASK  = 8'hFE;
    localparam logic [7:0] OPC_IMM_RM       = 8'hC6;
    localparam logic [7:0] OPC_IMM_REG_MASK = 8'hF0;
    localparam logic [7:0] OPC_IMM_REG      = 8'hB0;

    // ModRM codes
    localparam logic [1:0] MOD_MEM_NODISP = 2'd0;
    localparam logic [1:0] MOD_MEM_DISP8  = 2'd1;
    localparam logic [1:0] MOD_MEM_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REGISTER   = 2'd3;
    localparam logic [2:0] RM_DIRECT      = 3'b110;

    // Stream payload width: 50 bits of fields rounded up to whole bytes
    localparam int RESULT_BITS = 50;
    localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    // Number of displacement bytes that follow a ModRM byte
    function automatic logic [1:0] disp_count(input logic [7:0] modrm);
        logic [1:0] cnt;
        unique case (modrm[7:6])
            MOD_MEM_DISP8:  cnt = 2'd1;
            MOD_MEM_DISP16: cnt = 2'd2;
            MOD_MEM_NODISP: cnt = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default:        cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/x86_16_mov_decoder_unit.sv -----
`default_nettype none
// A result is registered into the output slot on m_tdata at the transfer of the
// last byte of its instruction (an unknown opcode byte is its own last byte).
// Throughput: one code byte per cycle; a skid register takes one more result
// while the output waits on m_tready, and s_tready drops once both are full.
// Reset: aresetn (synchronous, active low) empties both output slots and sets
// the decoder to expect an opcode byte with all held fields cleared.
module x86_16_mov_decoder_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] code_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] kind, [2] wide, [3] to_reg, [5:4] mode, [8:6] reg_field,
    // [11:9] rm_field, [12] direct_address, [28:13] displacement,
    // [30:29] disp_bytes, [46:31] immediate, [49:47] length, [55:50] zero
    output logic [x86mov_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int DW = x86mov_pkg::M_TDATA_W;

    // Decoder state
    x86mov_pkg::phase_t phase_reg, phase_next;
    x86mov_pkg::kind_t  kind_reg, kind_next;
    logic [1:0]         flags_reg, flags_next;   // bit 0 w, bit 1 d
    logic [7:0]         modrm_reg, modrm_next;
    logic [15:0]        disp_reg, disp_next;
    logic [15:0]        imm_reg, imm_next;
    logic [2:0]         count_reg, count_next;

    // Output slot and skid slot
    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;
    logic          skid_valid_reg;
    logic [DW-1:0] skid_data_reg;

    logic          accept;
    logic          emit;
    logic          produce;
    logic [DW-1:0] result;

    // Result fields
    logic       res_to_reg;
    logic       res_direct;
    logic [1:0] res_disp_bytes;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign produce  = accept && emit;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Per-byte decode: next held state and completion
    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        flags_next = flags_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        count_next = 3'(count_reg + 3'd1);
        emit       = 1'b0;
        unique case (phase_reg)
            x86mov_pkg::PH_MODRM: begin
                modrm_next = s_tdata;
                if (x86mov_pkg::disp_count(s_tdata) != 2'd0) begin
                    phase_next = x86mov_pkg::PH_DISP_LO;
                end else if (kind_reg == x86mov_pkg::K_REGMEM) begin
                    emit       = 1'b1;
                    phase_next = x86mov_pkg::PH_OPCODE;
                end else begin
                    phase_next = x86mov_pkg::PH_IMM_LO;
                end
            end
            x86mov_pkg::PH_DISP_LO: begin
                disp_next = {8'h00, s_tdata};
                if (x86mov_pkg::disp_count(modrm_reg) == 2'd2) begin
                    phase_next = x86mov_pkg::PH_DISP_HI;
                end else if (kind_reg == x86mov_pkg::K_REGMEM) begin
                    emit       = 1'b1;
                    phase_next = x86mov_pkg::PH_OPCODE;
                end else begin
                    phase_next = x86mov_pkg::PH_IMM_LO;
                end
            end
            x86mov_pkg::PH_DISP_HI: begin
                disp_next = {s_tdata, disp_reg[7:0]};
                if (kind_reg == x86mov_pkg::K_REGMEM) begin
                    emit       = 1'b1;
                    phase_next = x86mov_pkg::PH_OPCODE;
                end else begin
                    phase_next = x86mov_pkg::PH_IMM_LO;
                end
            end
            x86mov_pkg::PH_IMM_LO: begin
                imm_next = {8'h00, s_tdata};
                if (flags_reg[0]) begin
                    phase_next = x86mov_pkg::PH_IMM_HI;
                end else begin
                    emit       = 1'b1;
                    phase_next = x86mov_pkg::PH_OPCODE;
                end
            end
            x86mov_pkg::PH_IMM_HI: begin
                imm_next   = {s_tdata, imm_reg[7:0]};
                emit       = 1'b1;
                phase_next = x86mov_pkg::PH_OPCODE;
            end
            default: begin
                // opcode byte; unused phase codes land here too
                count_next = 3'd1;
                disp_next  = 16'h0000;
                imm_next   = 16'h0000;
                modrm_next = 8'h00;
                priority if ((s_tdata & x86mov_pkg::OPC_REGMEM_MASK)
                             == x86mov_pkg::OPC_REGMEM) begin
                    kind_next  = x86mov_pkg::K_REGMEM;
                    flags_next = s_tdata[1:0];
                    phase_next = x86mov_pkg::PH_MODRM;
                end else if ((s_tdata & x86mov_pkg::OPC_IMM_RM_MASK)
                             == x86mov_pkg::OPC_IMM_RM) begin
                    kind_next  = x86mov_pkg::K_IMM_RM;
                    flags_next = {1'b0, s_tdata[0]};
                    phase_next = x86mov_pkg::PH_MODRM;
                end else if ((s_tdata & x86mov_pkg::OPC_IMM_REG_MASK)
                             == x86mov_pkg::OPC_IMM_REG) begin
                    kind_next  = x86mov_pkg::K_IMM_REG;
                    flags_next = {1'b0, s_tdata[3]};
                    modrm_next = {x86mov_pkg::MOD_REGISTER, s_tdata[2:0], 3'b000};
                    phase_next = x86mov_pkg::PH_IMM_LO;
                end else begin
                    // unknown opcode: one-byte error result
                    kind_next  = x86mov_pkg::K_UNKNOWN;
                    flags_next = 2'b00;
                    emit       = 1'b1;
                    phase_next = x86mov_pkg::PH_OPCODE;
                end
            end
        endcase
    end

    // Result assembly from the updated held fields
    always_comb begin
        res_to_reg = (kind_next == x86mov_pkg::K_IMM_REG) ? 1'b1 : flags_next[1];
        res_direct = (kind_next != x86mov_pkg::K_IMM_REG)
                     && (modrm_next[7:6] == x86mov_pkg::MOD_MEM_NODISP)
                     && (modrm_next[2:0] == x86mov_pkg::RM_DIRECT);
        res_disp_bytes = (kind_next == x86mov_pkg::K_IMM_REG)
                         ? 2'd0 : x86mov_pkg::disp_count(modrm_next);
        result = DW'({count_next, imm_next, res_disp_bytes, disp_next, res_direct,
                      modrm_next[2:0], modrm_next[5:3], modrm_next[7:6],
                      res_to_reg, flags_next[0], kind_next});
    end

    // Decoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= x86mov_pkg::PH_OPCODE;
            kind_reg  <= x86mov_pkg::K_REGMEM;
            flags_reg <= 2'b00;
            modrm_reg <= 8'h00;
            disp_reg  <= 16'h0000;
            imm_reg   <= 16'h0000;
            count_reg <= 3'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            flags_reg <= flags_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
            count_reg <= count_next;
        end
    end

    // Output register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= produce;
            end
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (produce && out_valid_reg && !m_tready) begin
            skid_data_reg <= result;
        end
    end

    // Skid slot holds data only behind a full output slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot filled while output slot empty");

    // Skid slot fills only when a result met a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid slot filled without output stall");

    // Every completed instruction returns the decoder to the opcode phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> phase_reg == x86mov_pkg::PH_OPCODE)
        else $error("decoder not back at opcode after result");

    // A completed instruction is one to six bytes long
    assert property (@(posedge aclk) disable iff (!aresetn)
        produce |-> (count_next != 3'd0) && (count_next != 3'd7))
        else $error("instruction length out of range");

endmodule

`default_nettype wire

// ----- bench/x86_16_mov_decoder_unit_tb.sv -----
module x86_16_mov_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_BYTES = 1650;
    localparam int          DIR_ROWS     = 23;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned CALM_START   = 1500;   // window with no idling on either side
    localparam int unsigned CALM_END     = 2000;
    localparam int unsigned HOLD_START   = 400;    // long receiver hold-off
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam bit          ROW_UNKNOWN  = 1'b1;   // row carries the unknown-opcode result
    localparam bit          ROW_DECODE   = 1'b0;   // row is checked by the decoder model

    // One decoded instruction, as carried on m_tdata
    typedef struct {
        x86mov_pkg::kind_t kind;
        logic              wide;
        logic              to_reg;
        logic [1:0]        mode;
        logic [2:0]        reg_field;
        logic [2:0]        rm_field;
        logic              direct_address;
        logic [15:0]       displacement;
        logic [1:0]        disp_bytes;
        logic [15:0]       immediate;
        logic [2:0]        length;
    } mov_decode_t;

    typedef struct {
        logic [7:0] code;
        bit         check_unknown;
    } code_item_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata = 8'h00;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [x86mov_pkg::M_TDATA_W-1:0] m_tdata;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    logic        calm_window;

    code_item_t  code_stream[$];
    mov_decode_t pending_decodes[$];
    logic [8:0]  directed_rows [DIR_ROWS];

    mov_decode_t unknown_fields = '{x86mov_pkg::K_UNKNOWN, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0,
                                    1'b0, 16'h0000, 2'd0, 16'h0000, 3'd1};

    // Decoder model state
    x86mov_pkg::phase_t dec_phase = x86mov_pkg::PH_OPCODE;
    x86mov_pkg::kind_t  dec_kind = x86mov_pkg::K_REGMEM;
    logic               dec_wide = 1'b0;
    logic               dec_dir = 1'b0;
    logic [7:0]         dec_modrm = 8'h00;
    logic [15:0]        dec_disp = 16'h0000;
    logic [15:0]        dec_imm = 16'h0000;
    logic [2:0]         dec_count = 3'd0;

    x86_16_mov_decoder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    assign calm_window = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    // Displacement bytes that follow a ModRM byte
    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        if (modrm[7:6] == x86mov_pkg::MOD_MEM_DISP16)
            return 2'd2;
        if (modrm[7:6] == x86mov_pkg::MOD_MEM_DISP8)
            return 2'd1;
        if (modrm[7:6] == x86mov_pkg::MOD_MEM_NODISP && modrm[2:0] == x86mov_pkg::RM_DIRECT)
            return 2'd2;
        return 2'd0;
    endfunction

    // Advance the decoder model by one code byte; produced marks a finished instruction
    task automatic decode_byte(input logic [7:0] b, output bit produced,
                               output mov_decode_t r);
        bit operands_done;
        produced = 1'b0;
        operands_done = 1'b0;
        r = unknown_fields;
        case (dec_phase)
            x86mov_pkg::PH_MODRM: begin
                dec_count = dec_count + 3'd1;
                dec_modrm = b;
                if (disp_len(b) != 2'd0)
                    dec_phase = x86mov_pkg::PH_DISP_LO;
                else
                    operands_done = 1'b1;
            end
            x86mov_pkg::PH_DISP_LO: begin
                dec_count = dec_count + 3'd1;
                dec_disp = {8'h00, b};
                if (disp_len(dec_modrm) == 2'd2)
                    dec_phase = x86mov_pkg::PH_DISP_HI;
                else
                    operands_done = 1'b1;
            end
            x86mov_pkg::PH_DISP_HI: begin
                dec_count = dec_count + 3'd1;
                dec_disp[15:8] = b;
                operands_done = 1'b1;
            end
            x86mov_pkg::PH_IMM_LO: begin
                dec_count = dec_count + 3'd1;
                dec_imm = {8'h00, b};
                if (dec_wide)
                    dec_phase = x86mov_pkg::PH_IMM_HI;
                else
                    produced = 1'b1;
            end
            x86mov_pkg::PH_IMM_HI: begin
                dec_count = dec_count + 3'd1;
                dec_imm[15:8] = b;
                produced = 1'b1;
            end
            default: begin
                // opcode byte: clear held operands and classify
                dec_count = 3'd1;
                dec_disp = 16'h0000;
                dec_imm = 16'h0000;
                dec_modrm = 8'h00;
                dec_dir = 1'b0;
                dec_wide = 1'b0;
                if ((b & x86mov_pkg::OPC_REGMEM_MASK) == x86mov_pkg::OPC_REGMEM) begin
                    dec_kind = x86mov_pkg::K_REGMEM;
                    dec_wide = b[0];
                    dec_dir = b[1];
                    dec_phase = x86mov_pkg::PH_MODRM;
                end else if ((b & x86mov_pkg::OPC_IMM_RM_MASK) == x86mov_pkg::OPC_IMM_RM) begin
                    dec_kind = x86mov_pkg::K_IMM_RM;
                    dec_wide = b[0];
                    dec_phase = x86mov_pkg::PH_MODRM;
                end else if ((b & x86mov_pkg::OPC_IMM_REG_MASK)
                             == x86mov_pkg::OPC_IMM_REG) begin
                    dec_kind = x86mov_pkg::K_IMM_REG;
                    dec_wide = b[3];
                    dec_modrm = {x86mov_pkg::MOD_REGISTER, b[2:0], 3'd0};
                    dec_phase = x86mov_pkg::PH_IMM_LO;
                end else begin
                    // unknown opcode reports at once with everything else cleared
                    dec_kind = x86mov_pkg::K_UNKNOWN;
                    produced = 1'b1;
                end
            end
        endcase

        // register moves end after the displacement, immediate forms go on to data
        if (operands_done) begin
            if (dec_kind == x86mov_pkg::K_REGMEM)
                produced = 1'b1;
            else
                dec_phase = x86mov_pkg::PH_IMM_LO;
        end

        if (produced) begin
            r.kind = dec_kind;
            r.wide = dec_wide;
            r.to_reg = (dec_kind == x86mov_pkg::K_IMM_REG) ? 1'b1 : dec_dir;
            r.mode = dec_modrm[7:6];
            r.reg_field = dec_modrm[5:3];
            r.rm_field = dec_modrm[2:0];
            r.direct_address = (dec_kind != x86mov_pkg::K_IMM_REG)
                               && (dec_modrm[7:6] == x86mov_pkg::MOD_MEM_NODISP)
                               && (dec_modrm[2:0] == x86mov_pkg::RM_DIRECT);
            r.displacement = dec_disp;
            r.disp_bytes = (dec_kind == x86mov_pkg::K_IMM_REG) ? 2'd0 : disp_len(dec_modrm);
            r.immediate = dec_imm;
            r.length = dec_count;
            dec_phase = x86mov_pkg::PH_OPCODE;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] code, input bit check_unknown);
        code_item_t item;
        item.code = code;
        item.check_unknown = check_unknown;
        code_stream.push_back(item);
    endtask

    // Input and result transfers, both seen at the same rising edge
    always @(posedge aclk) begin : transfer_monitor
        mov_decode_t want;
        mov_decode_t got;
        code_item_t  item;
        bit          produced;
        int unsigned accepted;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                item = code_stream[accepted];
                accepted++;
                decode_byte(s_tdata, produced, want);
                if (item.check_unknown)
                    pending_decodes.push_back(unknown_fields);
                else if (produced)
                    pending_decodes.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.kind = x86mov_pkg::kind_t'(m_tdata[1:0]);
                got.wide = m_tdata[2];
                got.to_reg = m_tdata[3];
                got.mode = m_tdata[5:4];
                got.reg_field = m_tdata[8:6];
                got.rm_field = m_tdata[11:9];
                got.direct_address = m_tdata[12];
                got.displacement = m_tdata[28:13];
                got.disp_bytes = m_tdata[30:29];
                got.immediate = m_tdata[46:31];
                got.length = m_tdata[49:47];
                if (pending_decodes.size() == 0) begin
                    $error("result transfer with no decoded instruction pending");
                    fail_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("wide", want.wide, got.wide);
                    check_field("to_reg", want.to_reg, got.to_reg);
                    check_field("mode", want.mode, got.mode);
                    check_field("reg_field", want.reg_field, got.reg_field);
                    check_field("rm_field", want.rm_field, got.rm_field);
                    check_field("direct_address", want.direct_address, got.direct_address);
                    check_field("displacement", want.displacement, got.displacement);
                    check_field("disp_bytes", want.disp_bytes, got.disp_bytes);
                    check_field("immediate", want.immediate, got.immediate);
                    check_field("length", want.length, got.length);
                end
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned held;
        bit          hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && cycle_count >= HOLD_START) begin
                hold_done = 1'b1;
                m_tready = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
            end else begin
                m_tready = calm_window || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : code_source
        int         form_pick;
        logic [7:0] modrm;
        logic [7:0] code;
        bit         wide_bit;

        // Directed part: opcode extremes, each MOV form, and register, disp8, disp16 and direct addressing
        directed_rows = '{
            {ROW_UNKNOWN, 8'h00},                                   // unknown, low extreme
            {ROW_UNKNOWN, 8'hFF},                                   // unknown, high extreme
            {ROW_DECODE, 8'h89}, {ROW_DECODE, 8'hD8},               // mov ax, bx
            {ROW_DECODE, 8'h8A}, {ROW_DECODE, 8'h46},               // byte disp, zero-extended
            {ROW_DECODE, 8'h80},
            {ROW_DECODE, 8'h8B}, {ROW_DECODE, 8'h0E},               // direct address
            {ROW_DECODE, 8'h34}, {ROW_DECODE, 8'h12},
            {ROW_DECODE, 8'h88}, {ROW_DECODE, 8'h97},               // word disp, all ones
            {ROW_DECODE, 8'hFF}, {ROW_DECODE, 8'hFF},
            {ROW_DECODE, 8'hC7}, {ROW_DECODE, 8'h06},               // imm word to direct addr
            {ROW_DECODE, 8'h00}, {ROW_DECODE, 8'h01},
            {ROW_DECODE, 8'hFF}, {ROW_DECODE, 8'hFF},
            {ROW_DECODE, 8'hB0}, {ROW_DECODE, 8'hFF}                // mov al, imm8
        };
        foreach (directed_rows[i])
            queue_byte(directed_rows[i][7:0], directed_rows[i][8]);

        // Random part: mostly well-formed instructions, some unknown opcodes and noise
        while (code_stream.size() < DIR_ROWS + RANDOM_BYTES) begin
            form_pick = $urandom_range(0, 99);
            modrm = 8'($urandom);
            wide_bit = 1'($urandom);
            if (form_pick < 30) begin
                queue_byte(x86mov_pkg::OPC_REGMEM | 8'($urandom_range(0, 3)), ROW_DECODE);
                queue_byte(modrm, ROW_DECODE);
                repeat (disp_len(modrm)) queue_byte(8'($urandom), ROW_DECODE);
            end else if (form_pick < 55) begin
                queue_byte(x86mov_pkg::OPC_IMM_RM | {7'd0, wide_bit}, ROW_DECODE);
                queue_byte(modrm, ROW_DECODE);
                repeat (disp_len(modrm)) queue_byte(8'($urandom), ROW_DECODE);
                repeat (wide_bit ? 2 : 1) queue_byte(8'($urandom), ROW_DECODE);
            end else if (form_pick < 80) begin
                queue_byte(x86mov_pkg::OPC_IMM_REG | {4'd0, wide_bit, 3'($urandom)},
                           ROW_DECODE);
                repeat (wide_bit ? 2 : 1) queue_byte(8'($urandom), ROW_DECODE);
            end else if (form_pick < 90) begin
                do
                    code = 8'($urandom);
                while ((code & x86mov_pkg::OPC_REGMEM_MASK) == x86mov_pkg::OPC_REGMEM
                       || (code & x86mov_pkg::OPC_IMM_RM_MASK) == x86mov_pkg::OPC_IMM_RM
                       || (code & x86mov_pkg::OPC_IMM_REG_MASK) == x86mov_pkg::OPC_IMM_REG);
                queue_byte(code, ROW_DECODE);
            end else begin
                queue_byte(8'($urandom), ROW_DECODE);
            end
        end

        // Reset, held low and then released
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Offer every byte, with random gaps outside the calm window
        foreach (code_stream[i]) begin
            @(negedge aclk);
            while (!calm_window && $urandom_range(0, 99) < 33) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata = code_stream[i].code;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Drain outstanding results, then keep watching for stray results
        while (pending_decodes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_decodes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
